### hw/rtl/ceps_pkg.sv
// Shared types and constants for the console escape-sequence parser.
// No dependencies; every other file of the block imports this package.
package ceps_pkg;

   // Character codes recognized by the parser.
   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_BRACKET = 8'h5B;
   localparam logic [7:0] CH_K       = 8'h4B;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_H       = 8'h48;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   // Field widths.
   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int COORD_W = 15;
   localparam int VALUE_W = 14;
   localparam int DIGIT_W = 4;
   // Digit counters hold up to the largest supported digit limit (7).
   localparam int CNT_W   = 3;
   // Beat index inside one replay job (at most 3 + 2*MAX_DIGITS beats).
   localparam int STEP_W  = 5;

   // Result kinds on the output channel.
   localparam logic [KIND_W-1:0] KIND_TEXT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CURSOR = 2'd2;

   // Job codes passed from the front end to the back end.
   localparam logic [1:0] JOB_TEXT   = 2'd0;
   localparam logic [1:0] JOB_CLEAR  = 2'd1;
   localparam logic [1:0] JOB_CURSOR = 2'd2;
   localparam logic [1:0] JOB_REPLAY = 2'd3;

   // One job: everything but the held digits, whose count follows a parameter.
   typedef struct packed {
      logic [1:0]         code;
      logic [BYTE_W-1:0]  char_val;
      logic               tail_en;
      logic               semi;
      logic [CNT_W-1:0]   row_cnt;
      logic [CNT_W-1:0]   col_cnt;
      logic [COORD_W-1:0] row_coord;
      logic [COORD_W-1:0] col_coord;
   } job_type;

   localparam int JOB_W = $bits(job_type);

   // Queue status seen by both ends.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

### hw/rtl/ceps_if.sv
// Valid/ready channel interfaces for the parser's byte input and result output.
// Depends on ceps_pkg for field widths.
interface ceps_req_if import ceps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink (input valid, input byte_in, output ready);
endinterface

interface ceps_rsp_if import ceps_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic [BYTE_W-1:0]         text_char;
   logic signed [COORD_W-1:0] row;
   logic signed [COORD_W-1:0] column;
   logic                      last;

   modport source (output valid, output kind, output text_char, output row,
                   output column, output last, input ready);
   modport sink (input valid, input kind, input text_char, input row,
                 input column, input last, output ready);
endinterface

### hw/rtl/ceps_front.sv
// Front end: accepts bytes, runs the escape-sequence state machine, emits jobs.
// Depends on ceps_pkg and ceps_req_if.
module ceps_front import ceps_pkg::*; #(
   parameter int MAX_DIGITS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   ceps_req_if.sink                            req_chan,
   input  q_status_type                        q_status,
   output logic                                job_push,
   output job_type                             job,
   output logic [2*MAX_DIGITS-1:0][DIGIT_W-1:0] job_digits
);

   localparam int NDIG  = 2 * MAX_DIGITS;
   localparam int IDX_W = $clog2(NDIG);

   // Parser phases.
   localparam logic [2:0] PH_TEXT     = 3'd0;
   localparam logic [2:0] PH_ESC      = 3'd1;
   localparam logic [2:0] PH_BRACKET  = 3'd2;
   localparam logic [2:0] PH_ROW      = 3'd3;
   localparam logic [2:0] PH_COLSTART = 3'd4;
   localparam logic [2:0] PH_COL      = 3'd5;

   logic [2:0]         phase_ff, phase_in;
   logic [CNT_W-1:0]   row_cnt_ff, row_cnt_in;
   logic [CNT_W-1:0]   col_cnt_ff, col_cnt_in;
   logic [VALUE_W-1:0] row_val_ff, row_val_in;
   logic [VALUE_W-1:0] col_val_ff, col_val_in;
   logic [DIGIT_W-1:0] dig_ff [NDIG];

   logic               accept;
   logic [BYTE_W-1:0]  b;
   logic               is_digit;
   logic [DIGIT_W-1:0] d;
   logic               dig_we;
   logic [IDX_W-1:0]   dig_idx;
   logic               row_room;
   logic               col_room;
   logic [17:0]        row_acc;
   logic [17:0]        col_acc;

   assign req_chan.ready = !q_status.full;
   assign accept   = req_chan.valid && req_chan.ready;
   assign b        = req_chan.byte_in;
   assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
   assign d        = b[DIGIT_W-1:0];
   assign row_room = row_cnt_ff < CNT_W'(MAX_DIGITS);
   assign col_room = col_cnt_ff < CNT_W'(MAX_DIGITS);

   // Decimal accumulation, wrapped to the value width below.
   assign row_acc = {4'b0, row_val_ff} * 18'd10 + {14'b0, d};
   assign col_acc = {4'b0, col_val_ff} * 18'd10 + {14'b0, d};

   // Held digits are copied into every replay job.
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         job_digits[i] = dig_ff[i];
      end
   end

   // Next-state and job generation for one accepted byte.
   always_comb begin
      phase_in   = phase_ff;
      row_cnt_in = row_cnt_ff;
      col_cnt_in = col_cnt_ff;
      row_val_in = row_val_ff;
      col_val_in = col_val_ff;
      dig_we     = 1'b0;
      dig_idx    = '0;
      job_push   = 1'b0;

      job.code      = JOB_TEXT;
      job.char_val  = b;
      job.tail_en   = (b != CH_ESC);
      job.semi      = (phase_ff == PH_COLSTART) || (phase_ff == PH_COL);
      job.row_cnt   = row_cnt_ff;
      job.col_cnt   = col_cnt_ff;
      job.row_coord = {1'b0, row_val_ff} - COORD_W'(1);
      job.col_coord = {1'b0, col_val_ff} - COORD_W'(1);

      if (accept) begin
         case (phase_ff)
            PH_ESC: begin
               if (b == CH_BRACKET) begin
                  phase_in = PH_BRACKET;
               end else if (b == CH_ESC) begin
                  phase_in = PH_ESC;
               end else begin
                  phase_in = PH_TEXT;
                  job_push = 1'b1;
               end
            end
            PH_BRACKET: begin
               if (b == CH_K) begin
                  job.code = JOB_CLEAR;
                  job_push = 1'b1;
                  phase_in = PH_TEXT;
               end else if (is_digit) begin
                  dig_we     = 1'b1;
                  dig_idx    = '0;
                  row_cnt_in = CNT_W'(1);
                  row_val_in = VALUE_W'(d);
                  phase_in   = PH_ROW;
               end else begin
                  job.code = JOB_REPLAY;
                  job_push = 1'b1;
               end
            end
            PH_ROW: begin
               if (is_digit && row_room) begin
                  dig_we     = 1'b1;
                  dig_idx    = IDX_W'(row_cnt_ff);
                  row_cnt_in = row_cnt_ff + CNT_W'(1);
                  row_val_in = row_acc[VALUE_W-1:0];
               end else if (b == CH_SEMI) begin
                  phase_in = PH_COLSTART;
               end else begin
                  job.code = JOB_REPLAY;
                  job_push = 1'b1;
               end
            end
            PH_COLSTART: begin
               if (is_digit) begin
                  dig_we     = 1'b1;
                  dig_idx    = IDX_W'(MAX_DIGITS);
                  col_cnt_in = CNT_W'(1);
                  col_val_in = VALUE_W'(d);
                  phase_in   = PH_COL;
               end else begin
                  job.code = JOB_REPLAY;
                  job_push = 1'b1;
               end
            end
            PH_COL: begin
               if (is_digit && col_room) begin
                  dig_we     = 1'b1;
                  dig_idx    = IDX_W'(MAX_DIGITS) + IDX_W'(col_cnt_ff);
                  col_cnt_in = col_cnt_ff + CNT_W'(1);
                  col_val_in = col_acc[VALUE_W-1:0];
               end else if (b == CH_H) begin
                  job.code = JOB_CURSOR;
                  job_push = 1'b1;
                  phase_in = PH_TEXT;
               end else begin
                  job.code = JOB_REPLAY;
                  job_push = 1'b1;
               end
            end
            default: begin
               // Text mode: an escape opens a sequence, anything else is text.
               if (b == CH_ESC) begin
                  phase_in = PH_ESC;
               end else begin
                  phase_in = PH_TEXT;
                  job_push = 1'b1;
               end
            end
         endcase

         // Any result ends the sequence; a break-off restarts on the byte itself.
         if (job_push || (phase_ff != PH_ESC && b == CH_ESC && !dig_we)) begin
            if (job.code == JOB_REPLAY || job.code == JOB_CLEAR ||
                job.code == JOB_CURSOR || phase_ff == PH_TEXT) begin
               row_cnt_in = '0;
               col_cnt_in = '0;
               row_val_in = '0;
               col_val_in = '0;
            end
         end
         if (job_push && job.code == JOB_REPLAY) begin
            phase_in = (b == CH_ESC) ? PH_ESC : PH_TEXT;
         end
         // A break-off on an escape yields a replay job too.
         if ((phase_ff == PH_ROW || phase_ff == PH_COLSTART || phase_ff == PH_COL ||
              phase_ff == PH_BRACKET) && phase_in == PH_ESC) begin
            row_cnt_in = '0;
            col_cnt_in = '0;
            row_val_in = '0;
            col_val_in = '0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TEXT;
         row_cnt_ff <= '0;
         col_cnt_ff <= '0;
         row_val_ff <= '0;
         col_val_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         row_cnt_ff <= row_cnt_in;
         col_cnt_ff <= col_cnt_in;
         row_val_ff <= row_val_in;
         col_val_ff <= col_val_in;
      end
   end

   // Held digit store; entries are read only below the held counts.
   always_ff @(posedge clock) begin
      for (int i = 0; i < NDIG; i++) begin
         if (dig_we && int'(dig_idx) == i) begin
            dig_ff[i] <= d;
         end
      end
   end

endmodule

### hw/rtl/ceps_queue.sv
// Short first-in first-out job queue between the front and back ends.
// Depends on ceps_pkg for the status type.
module ceps_queue import ceps_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output q_status_type     status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_QW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = mem_ff[rd_ptr_ff];

   // Pointer and fill-count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/ceps_back.sv
// Back end: turns the queue head job into result beats, one per cycle when not stalled.
// Depends on ceps_pkg and ceps_rsp_if.
module ceps_back import ceps_pkg::*; #(
   parameter int MAX_DIGITS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 head_valid,
   input  job_type                              head_job,
   input  logic [2*MAX_DIGITS-1:0][DIGIT_W-1:0] head_digits,
   output logic                                 pop,
   ceps_rsp_if.source                           rsp_chan
);

   logic [STEP_W-1:0]  step_ff, step_in;
   logic               out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [BYTE_W-1:0]  char_ff, char_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [COORD_W-1:0] col_ff, col_in;
   logic               last_ff, last_in;

   logic               load;
   logic               beat_go;
   logic [STEP_W-1:0]  rc;
   logic [STEP_W-1:0]  cc;
   logic [STEP_W-1:0]  total;
   logic [BYTE_W-1:0]  replay_char;
   logic               replay_last;

   assign load    = !out_valid_ff || rsp_chan.ready;
   assign beat_go = head_valid && load;
   assign rc      = STEP_W'(head_job.row_cnt);
   assign cc      = STEP_W'(head_job.col_cnt);
   assign total   = STEP_W'(1) + rc + STEP_W'(head_job.semi) + cc
                    + STEP_W'(head_job.tail_en);
   assign replay_last = (step_ff == total - STEP_W'(1));

   // Character of the current replay beat: '[', row digits, ';', column digits, tail.
   always_comb begin
      replay_char = head_job.char_val;
      if (step_ff == '0) begin
         replay_char = CH_BRACKET;
      end else if (step_ff <= rc) begin
         for (int i = 0; i < MAX_DIGITS; i++) begin
            if (step_ff == STEP_W'(i + 1)) begin
               replay_char = CH_ZERO | {4'b0, head_digits[i]};
            end
         end
      end else if (head_job.semi && step_ff == rc + STEP_W'(1)) begin
         replay_char = CH_SEMI;
      end else if (head_job.semi && step_ff <= rc + STEP_W'(1) + cc) begin
         for (int i = 0; i < MAX_DIGITS; i++) begin
            if (step_ff == rc + STEP_W'(i + 2)) begin
               replay_char = CH_ZERO | {4'b0, head_digits[MAX_DIGITS + i]};
            end
         end
      end
   end

   // Beat formation and output register.
   always_comb begin
      kind_in = kind_ff;
      char_in = char_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      last_in = last_ff;
      pop     = 1'b0;
      step_in = step_ff;
      out_valid_in = rsp_chan.ready ? 1'b0 : out_valid_ff;

      if (beat_go) begin
         out_valid_in = 1'b1;
         row_in  = '0;
         col_in  = '0;
         char_in = '0;
         last_in = 1'b1;
         case (head_job.code)
            JOB_TEXT: begin
               kind_in = KIND_TEXT;
               char_in = head_job.char_val;
            end
            JOB_CLEAR: begin
               kind_in = KIND_CLEAR;
            end
            JOB_CURSOR: begin
               kind_in = KIND_CURSOR;
               row_in  = head_job.row_coord;
               col_in  = head_job.col_coord;
            end
            JOB_REPLAY: begin
               kind_in = KIND_TEXT;
               char_in = replay_char;
               last_in = replay_last;
            end
            default: begin
               kind_in = KIND_TEXT;
            end
         endcase
         pop     = last_in;
         step_in = last_in ? '0 : step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      char_ff <= char_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.kind      = kind_ff;
   assign rsp_chan.text_char = char_ff;
   assign rsp_chan.row       = row_ff;
   assign rsp_chan.column    = col_ff;
   assign rsp_chan.last      = last_ff;

endmodule

### hw/rtl/console_escape_sequence_parser_core.sv
// Top level of the console escape-sequence parser.
// Depends on ceps_pkg, ceps_if, ceps_front, ceps_queue and ceps_back.
//
// Usage:
//   req_chan carries one text byte per beat (byte_in). rsp_chan carries result
//   beats: kind (text, clear to end of line, set cursor), text_char, zero-based
//   row and column, and last, which marks the final result of an input byte.
//   Plain text, ESC[K and ESC[row;colH each give one result. A broken-off
//   sequence replays '[', the held digits and ';' as text before the breaking
//   byte, up to 3 + 2*MAX_DIGITS beats for one input byte. An opening ESC, the
//   '[' after it and up to MAX_DIGITS digit bytes per field give no result.
//   The job for a byte is written into the job queue; its first result beat
//   then passes from the queue head through the output register to rsp_chan.
//   Throughput: one byte per cycle while each byte gives at most one result;
//   the back end emits one beat per cycle while rsp_chan is ready, so a replay
//   job holds the queue head until all its beats are out. The QUEUE_DEPTH-entry
//   queue absorbs bursts; req_chan.ready drops only when that queue is full.
//   A stalled receiver holds the output register; the queue keeps taking jobs
//   until it fills. Reset clears the parser to text mode and empties the queue
//   and output register; no clearing pass is needed.
module console_escape_sequence_parser_core import ceps_pkg::*; #(
   parameter int MAX_DIGITS  = 4,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   ceps_req_if.sink   req_chan,
   ceps_rsp_if.source rsp_chan
);

   localparam int DIGS_W = 2 * MAX_DIGITS * DIGIT_W;
   localparam int QW     = JOB_W + DIGS_W;

   logic                                 q_push;
   job_type                              f_job;
   logic [2*MAX_DIGITS-1:0][DIGIT_W-1:0] f_digits;
   logic [QW-1:0]                        q_head;
   q_status_type                         q_status;
   logic                                 q_pop;
   job_type                              b_job;
   logic [2*MAX_DIGITS-1:0][DIGIT_W-1:0] b_digits;

   // Front end: parse bytes into jobs.
   ceps_front #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .q_status   (q_status),
      .job_push   (q_push),
      .job        (f_job),
      .job_digits (f_digits)
   );

   // Job queue between the two ends.
   ceps_queue #(
      .WIDTH(QW),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_digits, f_job}),
      .pop       (q_pop),
      .pop_data  (q_head),
      .status    (q_status)
   );

   assign b_job    = q_head[JOB_W-1:0];
   assign b_digits = q_head[QW-1:JOB_W];

   // Back end: expand jobs into result beats.
   ceps_back #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (!q_status.empty),
      .head_job    (b_job),
      .head_digits (b_digits),
      .pop         (q_pop),
      .rsp_chan    (rsp_chan)
   );

`ifndef SYNTHESIS
   // A job is never written into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_status.full)
      else $error("job pushed into full queue");

   // A job is never taken from an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_status.empty)
      else $error("job popped from empty queue");

   // Commands are always the final result of their byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind != KIND_TEXT) |-> rsp_chan.last)
      else $error("command beat without last");

   // No result beat is shown right after reset.
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> !rsp_chan.valid)
      else $error("result valid after reset");
`endif

endmodule
